[hdl/scaled_float_to_interval_core_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the float-to-interval core
// Shared concurrent assertion forms, clocked on clk with rst_n as disable.
// ---------------------------------------------------------------------------
`ifndef SCALED_FLOAT_TO_INTERVAL_CORE_DEFINES_SVH
`define SCALED_FLOAT_TO_INTERVAL_CORE_DEFINES_SVH

// same-cycle implication
`define SFTI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SFTI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/sfti_pkg.sv]
// ---------------------------------------------------------------------------
// sfti_pkg
// Types, codes and constants shared by the float-to-interval core.
// ---------------------------------------------------------------------------
package sfti_pkg;

  localparam int unsigned IN_DATA_W  = 120;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 88;

  localparam logic [62:0] SEC_LIMIT   = 63'd9000000000000000000;
  localparam logic [19:0] MICRO_SCALE = 20'd1000000;
  localparam logic [20:0] MICRO_FULL  = 21'd1000000;
  localparam logic [12:0] EXP_BIAS_M  = 13'd1075;  // bias plus fraction width

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_UNIT = 2'd1,
    STAT_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    UNIT_YEAR, UNIT_MONTH, UNIT_DAY, UNIT_HOUR, UNIT_MINUTE, UNIT_SECOND
  } unit_t;

  // what the back end has to do with a request
  typedef enum logic [2:0] {
    KIND_NULL, KIND_BAD, KIND_OVF, KIND_ZERO, KIND_NUM
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    unit_t       unit;
    logic        sign;
    logic [10:0] exp_f;
    logic [51:0] frac;
  } item_t;

  typedef struct packed {
    kind_t kind;
    logic  sign;
  } ctl_t;

  typedef struct packed {
    logic        result_null;
    status_t     status;
    logic [63:0] seconds;
    logic [20:0] microseconds;
  } res_t;

  // seconds per unit
  function automatic logic [24:0] unit_scale(unit_t u);
    logic [24:0] k;
    unique case (u)
      UNIT_YEAR:   k = 25'd31536000;
      UNIT_MONTH:  k = 25'd2592000;
      UNIT_DAY:    k = 25'd86400;
      UNIT_HOUR:   k = 25'd3600;
      UNIT_MINUTE: k = 25'd60;
      UNIT_SECOND: k = 25'd1;
      default:     k = 25'd1;
    endcase
    return k;
  endfunction

  // bit length of the unit scale minus one
  function automatic logic [4:0] unit_msb(unit_t u);
    logic [4:0] b;
    unique case (u)
      UNIT_YEAR:   b = 5'd24;
      UNIT_MONTH:  b = 5'd21;
      UNIT_DAY:    b = 5'd16;
      UNIT_HOUR:   b = 5'd11;
      UNIT_MINUTE: b = 5'd5;
      UNIT_SECOND: b = 5'd0;
      default:     b = 5'd0;
    endcase
    return b;
  endfunction

endpackage

[hdl/scaled_float_to_interval_core.sv]
// ---------------------------------------------------------------------------
// scaled_float_to_interval_core
// Converts a double amount and a unit name into seconds plus microseconds.
// ---------------------------------------------------------------------------
// Takes one request per clock while nothing stalls and returns one result per
// request, in order. A request passes one front register, the two-entry queue,
// seven arithmetic stages and the output register. The stage count is set by
// the two multiplies (mantissa by unit scale, split in two partial products,
// and fraction by one million) with the round and split steps registered
// between them. Back-pressure on the output stalls the arithmetic pipeline;
// the queue lets the front keep taking requests meanwhile until it fills.
module scaled_float_to_interval_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // value_bits[63:0], unit_chars[111:64], unit_len[114:112], zero pad
  input  logic [sfti_pkg::IN_DATA_W-1:0]   in_tdata,
  // value_is_null[0], unit_is_null[1]
  input  logic [sfti_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // status[1:0], seconds[65:2], microseconds[86:66], zero pad
  output logic [sfti_pkg::OUT_DATA_W-1:0]  out_tdata,
  // result_null[0]
  output logic                             out_tuser
);

  logic            fr_valid, fr_ready;
  sfti_pkg::item_t fr_item;
  logic            q_valid, q_ready;
  sfti_pkg::item_t q_item;
  sfti_pkg::res_t  res;

  sfti_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .fr_valid  (fr_valid),
    .fr_item   (fr_item),
    .fr_ready  (fr_ready)
  );

  sfti_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (fr_valid),
    .s_ready (fr_ready),
    .s_item  (fr_item),
    .m_valid (q_valid),
    .m_ready (q_ready),
    .m_item  (q_item)
  );

  sfti_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // pack the result fields
  assign out_tdata = {1'b0, res.microseconds, res.seconds, res.status};
  assign out_tuser = res.result_null;

endmodule

[hdl/sfti_front.sv]
// ---------------------------------------------------------------------------
// sfti_front
// Accepts requests, matches the unit name and classifies the amount.
// ---------------------------------------------------------------------------
module sfti_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sfti_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [sfti_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                            fr_valid,
  output sfti_pkg::item_t                 fr_item,
  input  logic                            fr_ready
);

  logic            valid_r, valid_nxt;
  sfti_pkg::item_t item_r, item_nxt;
  logic [7:0]      uc [6];
  logic [2:0]      ulen;
  logic            unit_ok;
  sfti_pkg::unit_t unit;

  // upper-case the name bytes
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      uc[i] = in_tdata[64 + 8*i +: 8];
      if (uc[i] >= 8'h61 && uc[i] <= 8'h7A) begin
        uc[i] = uc[i] - 8'h20;
      end
    end
  end

  assign ulen = in_tdata[114:112];

  // unit name match by length
  always_comb begin
    unit_ok = 1'b1;
    unit    = sfti_pkg::UNIT_SECOND;
    unique case (ulen)
      3'd2: begin
        priority if ({uc[0], uc[1]} == "YY") unit = sfti_pkg::UNIT_YEAR;
        else if ({uc[0], uc[1]} == "MM") unit = sfti_pkg::UNIT_MONTH;
        else if ({uc[0], uc[1]} == "DD") unit = sfti_pkg::UNIT_DAY;
        else if ({uc[0], uc[1]} == "HH") unit = sfti_pkg::UNIT_HOUR;
        else if ({uc[0], uc[1]} == "MI") unit = sfti_pkg::UNIT_MINUTE;
        else if ({uc[0], uc[1]} == "SS") unit = sfti_pkg::UNIT_SECOND;
        else unit_ok = 1'b0;
      end
      3'd3: begin
        if ({uc[0], uc[1], uc[2]} == "DAY") unit = sfti_pkg::UNIT_DAY;
        else unit_ok = 1'b0;
      end
      3'd4: begin
        priority if ({uc[0], uc[1], uc[2], uc[3]} == "YEAR") unit = sfti_pkg::UNIT_YEAR;
        else if ({uc[0], uc[1], uc[2], uc[3]} == "HOUR") unit = sfti_pkg::UNIT_HOUR;
        else unit_ok = 1'b0;
      end
      3'd5: begin
        if ({uc[0], uc[1], uc[2], uc[3], uc[4]} == "MONTH") unit = sfti_pkg::UNIT_MONTH;
        else unit_ok = 1'b0;
      end
      3'd6: begin
        priority if ({uc[0], uc[1], uc[2], uc[3], uc[4], uc[5]} == "MINUTE") begin
          unit = sfti_pkg::UNIT_MINUTE;
        end else if ({uc[0], uc[1], uc[2], uc[3], uc[4], uc[5]} == "SECOND") begin
          unit = sfti_pkg::UNIT_SECOND;
        end else begin
          unit_ok = 1'b0;
        end
      end
      default: unit_ok = 1'b0;
    endcase
  end

  // classify: null first, then unit, then special amounts
  always_comb begin
    item_nxt.unit  = unit;
    item_nxt.sign  = in_tdata[63];
    item_nxt.exp_f = in_tdata[62:52];
    item_nxt.frac  = in_tdata[51:0];
    priority if (in_tuser[0] || in_tuser[1]) item_nxt.kind = sfti_pkg::KIND_NULL;
    else if (!unit_ok) item_nxt.kind = sfti_pkg::KIND_BAD;
    else if (in_tdata[62:52] == 11'h7FF) item_nxt.kind = sfti_pkg::KIND_OVF;
    else if (in_tdata[62:52] == 11'h000) item_nxt.kind = sfti_pkg::KIND_ZERO;
    else item_nxt.kind = sfti_pkg::KIND_NUM;
  end

  assign in_tready = !valid_r || fr_ready;
  assign valid_nxt = in_tready ? in_tvalid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= item_nxt;
    end
  end

  assign fr_valid = valid_r;
  assign fr_item  = item_r;

endmodule

[hdl/sfti_queue.sv]
// ---------------------------------------------------------------------------
// sfti_queue
// Two-entry queue between the classifying front and the arithmetic back.
// ---------------------------------------------------------------------------
`include "scaled_float_to_interval_core_defines.svh"

module sfti_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            s_valid,
  output logic            s_ready,
  input  sfti_pkg::item_t s_item,
  output logic            m_valid,
  input  logic            m_ready,
  output sfti_pkg::item_t m_item
);

  sfti_pkg::item_t mem [2];
  logic [1:0]      count_r, count_nxt;
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic            push, pop;

  assign s_ready = (count_r != 2'd2);
  assign m_valid = (count_r != 2'd0);
  assign push    = s_valid && s_ready;
  assign pop     = m_valid && m_ready;
  assign m_item  = mem[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= s_item;
    end
  end

  `SFTI_ASSERT_NXT(a_q_fill, push && !pop && count_r == 2'd1, count_r == 2'd2, "queue did not fill")
  `SFTI_ASSERT_NXT(a_q_drain, pop && !push && count_r == 2'd1, !m_valid, "queue did not drain")
  `SFTI_ASSERT_IMP(a_q_ptrs, count_r == 2'd0 || count_r == 2'd2, wr_ptr_r == rd_ptr_r, "queue pointers out of step")

endmodule

[hdl/sfti_back.sv]
// ---------------------------------------------------------------------------
// sfti_back
// Seven-stage arithmetic pipeline plus output register: scale, round,
// split into seconds and fraction, convert the fraction to microseconds.
// ---------------------------------------------------------------------------
`include "scaled_float_to_interval_core_defines.svh"

module sfti_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  sfti_pkg::item_t q_item,
  output logic            out_valid,
  input  logic            out_ready,
  output sfti_pkg::res_t  out_res
);

  // position of the highest set bit
  function automatic logic [5:0] msb_pos(logic [52:0] f);
    logic [5:0] p;
    p = 6'd0;
    for (int i = 0; i < 53; i++) begin
      if (f[i]) p = 6'(i);
    end
    return p;
  endfunction

  logic en;
  logic [7:1] vld_r;
  logic       out_valid_r;

  sfti_pkg::ctl_t ctl1_r, ctl2_r, ctl3_r, ctl4_r, ctl5_r, ctl6_r, ctl7_r;
  sfti_pkg::ctl_t ctl1_nxt, ctl4_nxt;

  // all stages advance together when the output can move
  assign en      = !out_valid_r || out_ready;
  assign q_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[6:1], q_valid};
      out_valid_r <= vld_r[7];
    end
  end

  // stage 1: mantissa times unit scale, two partial products
  logic [52:0] ma;
  logic [24:0] k1;
  logic [51:0] lo1_r, lo1_nxt;
  logic [50:0] hi1_r, hi1_nxt;
  logic [10:0] exp1_r;
  logic [4:0]  kb1_r;

  always_comb begin
    ma       = {1'b1, q_item.frac};
    k1       = sfti_pkg::unit_scale(q_item.unit);
    lo1_nxt  = 52'({25'd0, ma[26:0]}) * 52'({27'd0, k1});
    hi1_nxt  = 51'({25'd0, ma[52:27]}) * 51'({26'd0, k1});
    ctl1_nxt = '{kind: q_item.kind, sign: q_item.sign};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo1_r  <= lo1_nxt;
      hi1_r  <= hi1_nxt;
      exp1_r <= q_item.exp_f;
      kb1_r  <= sfti_pkg::unit_msb(q_item.unit);
      ctl1_r <= ctl1_nxt;
    end
  end

  // stage 2: sum the partial products
  logic [77:0] n2_r, n2_nxt;
  logic [10:0] exp2_r;
  logic [4:0]  kb2_r;

  assign n2_nxt = {hi1_r, 27'd0} + {26'd0, lo1_r};

  always_ff @(posedge clk) begin
    if (en) begin
      n2_r   <= n2_nxt;
      exp2_r <= exp1_r;
      kb2_r  <= kb1_r;
      ctl2_r <= ctl1_r;
    end
  end

  // stage 3: round the product to 53 bits, nearest even
  logic        hib3, up3;
  logic [4:0]  sh3;
  logic [52:0] m0_3;
  logic [53:0] m1_3;
  logic [25:0] rem3, half3;
  logic signed [12:0] e3;
  logic [52:0] mant3_r, mant3_nxt;
  logic signed [12:0] exp3_r, exp3_nxt;

  always_comb begin
    hib3  = n2_r[7'd53 + 7'(kb2_r)];
    sh3   = kb2_r + 5'(hib3);
    m0_3  = 53'(n2_r >> sh3);
    rem3  = n2_r[25:0] & ~({26{1'b1}} << sh3);
    half3 = 26'((27'd1 << sh3) >> 1);
    up3   = (sh3 != 5'd0) && ((rem3 > half3) || ((rem3 == half3) && m0_3[0]));
    m1_3  = {1'b0, m0_3} + 54'(up3);
    e3    = $signed({2'b00, exp2_r}) - $signed(sfti_pkg::EXP_BIAS_M) + $signed({8'd0, sh3});
    if (m1_3[53]) begin
      mant3_nxt = m1_3[53:1];
      exp3_nxt  = e3 + 13'sd1;
    end else begin
      mant3_nxt = m1_3[52:0];
      exp3_nxt  = e3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mant3_r <= mant3_nxt;
      exp3_r  <= exp3_nxt;
      ctl3_r  <= ctl2_r;
    end
  end

  // stage 4: integer seconds, fraction bits, overflow check
  logic [62:0] whole4_r, whole4_nxt;
  logic [52:0] f4_r, f4_nxt;
  logic [6:0]  s4_r, s4_nxt;
  logic [12:0] neg4;
  logic        ovf4;

  always_comb begin
    neg4 = 13'(-exp3_r);
    if (exp3_r >= 13'sd0) begin
      whole4_nxt = 63'({10'd0, mant3_r} << exp3_r[3:0]);
      f4_nxt     = 53'd0;
      s4_nxt     = 7'd0;
    end else begin
      s4_nxt     = (neg4 > 13'd75) ? 7'd75 : neg4[6:0];
      whole4_nxt = 63'({10'd0, mant3_r} >> s4_nxt);
      f4_nxt     = mant3_r & ~({53{1'b1}} << s4_nxt);
    end
    ovf4     = (exp3_r >= 13'sd11) || (whole4_nxt > sfti_pkg::SEC_LIMIT);
    ctl4_nxt = ctl3_r;
    if (ctl3_r.kind == sfti_pkg::KIND_NUM && ovf4) begin
      ctl4_nxt.kind = sfti_pkg::KIND_OVF;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      whole4_r <= whole4_nxt;
      f4_r     <= f4_nxt;
      s4_r     <= s4_nxt;
      ctl4_r   <= ctl4_nxt;
    end
  end

  // stage 5: fraction times one million, leading bit of the fraction
  logic [72:0] g5_r, g5_nxt;
  logic [5:0]  pf5_r;
  logic [62:0] whole5_r;
  logic [6:0]  s5_r;

  assign g5_nxt = 73'({20'd0, f4_r}) * 73'({53'd0, sfti_pkg::MICRO_SCALE});

  always_ff @(posedge clk) begin
    if (en) begin
      g5_r     <= g5_nxt;
      pf5_r    <= msb_pos(f4_r);
      whole5_r <= whole4_r;
      s5_r     <= s4_r;
      ctl5_r   <= ctl4_r;
    end
  end

  // stage 6: round the scaled fraction to 53 significant bits
  logic        hig6, up6;
  logic [6:0]  msb6;
  logic [4:0]  d6;
  logic [52:0] keep6;
  logic [19:0] rem6, half6;
  logic [73:0] g6_r, g6_nxt;
  logic [62:0] whole6_r;
  logic [6:0]  s6_r;

  always_comb begin
    hig6   = g5_r[7'(pf5_r) + 7'd20];
    msb6   = 7'(pf5_r) + 7'd19 + 7'(hig6);
    d6     = (msb6 > 7'd52) ? 5'(msb6 - 7'd52) : 5'd0;
    keep6  = 53'(g5_r >> d6);
    rem6   = g5_r[19:0] & ~({20{1'b1}} << d6);
    half6  = 20'((21'd1 << d6) >> 1);
    up6    = (d6 != 5'd0) && ((rem6 > half6) || ((rem6 == half6) && keep6[0]));
    g6_nxt = 74'({20'd0, {1'b0, keep6} + 54'(up6)}) << d6;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g6_r     <= g6_nxt;
      whole6_r <= whole5_r;
      s6_r     <= s5_r;
      ctl6_r   <= ctl5_r;
    end
  end

  // stage 7: whole microseconds, half-up rounding, carry into seconds
  logic [6:0]  sm1_7;
  logic [73:0] shr7;
  logic        ge7, carry7;
  logic [19:0] mw7;
  logic [20:0] mic7;
  logic [63:0] secs7_r, secs7_nxt;
  logic [20:0] mic7_r, mic7_nxt;

  always_comb begin
    mw7       = 20'(g6_r >> s6_r);
    sm1_7     = s6_r - 7'd1;
    shr7      = g6_r >> sm1_7;
    ge7       = (s6_r != 7'd0) && shr7[0];
    mic7      = {1'b0, mw7} + 21'(ge7);
    carry7    = (mic7 == sfti_pkg::MICRO_FULL);
    secs7_nxt = {1'b0, whole6_r} + 64'(carry7);
    mic7_nxt  = carry7 ? 21'd0 : mic7;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      secs7_r <= secs7_nxt;
      mic7_r  <= mic7_nxt;
      ctl7_r  <= ctl6_r;
    end
  end

  // output register: sign and status
  sfti_pkg::res_t res_r, res_nxt;

  always_comb begin
    res_nxt = '{result_null: 1'b0, status: sfti_pkg::STAT_OK,
                seconds: 64'd0, microseconds: 21'd0};
    unique case (ctl7_r.kind)
      sfti_pkg::KIND_NULL: res_nxt.result_null = 1'b1;
      sfti_pkg::KIND_BAD:  res_nxt.status = sfti_pkg::STAT_BAD_UNIT;
      sfti_pkg::KIND_OVF:  res_nxt.status = sfti_pkg::STAT_OVERFLOW;
      sfti_pkg::KIND_ZERO: res_nxt.status = sfti_pkg::STAT_OK;
      sfti_pkg::KIND_NUM: begin
        res_nxt.seconds      = ctl7_r.sign ? -secs7_r : secs7_r;
        res_nxt.microseconds = ctl7_r.sign ? -mic7_r : mic7_r;
      end
      default: res_nxt.status = sfti_pkg::STAT_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  `SFTI_ASSERT_NXT(a_stall_hold, !en, $stable(vld_r), "pipeline moved while stalled")
  `SFTI_ASSERT_NXT(a_last_feed, en && vld_r[7], out_valid_r, "last stage lost a request")
  `SFTI_ASSERT_IMP(a_ovf_clear, out_valid_r && res_r.status == sfti_pkg::STAT_OVERFLOW,
    res_r.seconds == 64'd0 && res_r.microseconds == 21'd0, "overflow result not cleared")
  `SFTI_ASSERT_IMP(a_micro_range, out_valid_r,
    $signed(res_r.microseconds) < 21'sd1000000 && $signed(res_r.microseconds) > -21'sd1000000,
    "microseconds out of range")

endmodule

[bench/tb_scaled_float_to_interval_core.sv]
// ---------------------------------------------------------------------------
// tb_scaled_float_to_interval_core
// Self-checking bench for the float-to-interval core: a queued stream driver,
// an in-order result monitor and a real-arithmetic interval predictor.
// ---------------------------------------------------------------------------
module tb_scaled_float_to_interval_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RST_CYCLES = 12;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 30;

  typedef struct packed {
    logic [63:0] value_bits;
    logic        value_is_null;
    logic [47:0] unit_chars;
    logic [2:0]  unit_len;
    logic        unit_is_null;
  } request_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [sfti_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic [sfti_pkg::IN_USER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [sfti_pkg::OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;

  request_t         pending_reqs[$];
  request_t         cur_req;
  sfti_pkg::res_t   expected_results[$];
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       mismatches = 0;
  int       quiet_cycles = 0;

  scaled_float_to_interval_core dut (.*);

  always #5 clk = ~clk;

  // long names by unit index, two-letter aliases alongside
  function automatic string unit_word(int u, bit alias_form);
    string names[6] = '{"YEAR", "MONTH", "DAY", "HOUR", "MINUTE", "SECOND"};
    string short_names[6] = '{"YY", "MM", "DD", "HH", "MI", "SS"};
    return alias_form ? short_names[u] : names[u];
  endfunction

  function automatic real unit_seconds(int u);
    real k[6] = '{31536000.0, 2592000.0, 86400.0, 3600.0, 60.0, 1.0};
    return k[u];
  endfunction

  // unit index 0..5, or -1 for no match
  function automatic int lookup_unit(logic [47:0] chars, logic [2:0] len);
    string nm;
    bit    ok;
    logic [7:0] c;
    if (len < 2 || len > 6) return -1;
    for (int u = 0; u < 6; u++) begin
      nm = unit_word(u, len == 2);
      if (nm.len() != len) continue;
      ok = 1;
      for (int i = 0; i < len; i++) begin
        c = chars[8*i +: 8];
        if (c >= "a" && c <= "z") c = c - 8'd32;
        if (c != nm[i]) ok = 0;
      end
      if (ok) return u;
    end
    return -1;
  endfunction

  // drop fraction bits of a finite double
  function automatic real trunc_real(real x);
    logic [63:0] b;
    int e;
    b = $realtobits(x);
    e = b[62:52];
    if (e >= 1075) return x;
    if (e < 1023) return $bitstoreal({b[63], 63'd0});
    b = b & ~((64'd1 << (1075 - e)) - 64'd1);
    return $bitstoreal(b);
  endfunction

  // exact integer of an integral double that fits in 64 bits
  function automatic longint integral_to_int(real x);
    logic [63:0] b;
    logic [63:0] mag;
    int e;
    b = $realtobits(x);
    e = b[62:52];
    if (e < 1023) return 0;
    mag = {11'd0, 1'b1, b[51:0]};
    if (e >= 1075) mag = mag << (e - 1075);
    else mag = mag >> (1075 - e);
    return b[63] ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic sfti_pkg::res_t predict_interval(request_t r);
    sfti_pkg::res_t res;
    int     u;
    real    product, whole, frac, scaled, micro_whole, rem;
    longint secs, micros;
    res = '0;
    res.status = sfti_pkg::STAT_OK;
    if (r.value_is_null || r.unit_is_null) begin
      res.result_null = 1'b1;
      return res;
    end
    u = lookup_unit(r.unit_chars, r.unit_len);
    if (u < 0) begin
      res.status = sfti_pkg::STAT_BAD_UNIT;
      return res;
    end
    product = $bitstoreal(r.value_bits) * unit_seconds(u);
    if ($realtobits(product) >> 52 == 12'h7ff || $realtobits(product) >> 52 == 12'hfff) begin
      res.status = sfti_pkg::STAT_OVERFLOW;
      return res;
    end
    whole = trunc_real(product);
    if (whole > 9e18 || whole < -9e18) begin
      res.status = sfti_pkg::STAT_OVERFLOW;
      return res;
    end
    frac = product - whole;
    secs = integral_to_int(whole);
    scaled = frac * 1e6;
    micro_whole = trunc_real(scaled);
    rem = scaled - micro_whole;
    micros = integral_to_int(micro_whole);
    if (rem >= 0.5) micros++;
    else if (rem <= -0.5) micros--;
    // rounding carry into seconds
    if (micros >= 1000000) begin
      secs++;
      micros = 0;
    end else if (micros <= -1000000) begin
      secs--;
      micros = 0;
    end
    res.seconds = secs;
    res.microseconds = micros[20:0];
    return res;
  endfunction

  // request with a given unit spelling; bytes above the name stay random
  function automatic request_t unit_request(logic [63:0] value, int u, bit alias_form,
                                            bit mixed_case);
    request_t r;
    string nm;
    logic [7:0] c;
    nm = unit_word(u, alias_form);
    r.value_bits = value;
    r.value_is_null = 1'b0;
    r.unit_is_null = 1'b0;
    r.unit_chars = 48'({$urandom, $urandom});
    r.unit_len = 3'(nm.len());
    for (int i = 0; i < nm.len(); i++) begin
      c = nm[i];
      if (mixed_case && $urandom_range(1)) c = c + 8'd32;
      r.unit_chars[8*i +: 8] = c;
    end
    return r;
  endfunction

  function automatic logic [63:0] random_value();
    int pick;
    logic [10:0] e;
    pick = $urandom_range(99);
    if (pick < 60) begin
      e = 11'($urandom_range(1023 + 66, 1023 - 30));
      return {1'($urandom), e, 20'($urandom), $urandom};
    end else if (pick < 75) begin
      return {$urandom, $urandom};
    end else if (pick < 88) begin
      // values that sit near a half microsecond
      return $realtobits(($itor($urandom_range(2000000)) + 0.5 * $urandom_range(1)
                          - 1000000.0) / 1e6);
    end else begin
      case ($urandom_range(5))
        0: return 64'h7ff0000000000000;
        1: return 64'hfff0000000000000;
        2: return {1'($urandom), 11'h7ff, 20'($urandom) | 20'h1, $urandom};
        3: return {1'($urandom), 63'd0};
        4: return {1'($urandom), 11'd0, 20'($urandom), $urandom};
        default: return $realtobits(($urandom_range(1) ? 9e18 : -9e18) /
                                    unit_seconds($urandom_range(5)));
      endcase
    end
  endfunction

  function automatic request_t random_request();
    request_t r;
    if ($urandom_range(99) < 80)
      r = unit_request(random_value(), $urandom_range(5), 1'($urandom_range(1)), 1'b1);
    else begin
      r.value_bits = random_value();
      r.unit_chars = 48'({$urandom, $urandom});
      r.unit_len = 3'($urandom);
      r.value_is_null = 1'b0;
      r.unit_is_null = 1'b0;
    end
    if ($urandom_range(99) < 4) r.value_is_null = 1'b1;
    if ($urandom_range(99) < 4) r.unit_is_null = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h", what, got, want);
    mismatches++;
  endtask

  // driver: hold a request until it is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) expected_results.push_back(predict_interval(cur_req));
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_req = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {5'd0, cur_req.unit_len, cur_req.unit_chars, cur_req.value_bits};
        in_tuser <= {cur_req.unit_is_null, cur_req.value_is_null};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    sfti_pkg::res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_tdata[65:2], 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_tuser !== want.result_null)
            report_mismatch("result_null", 64'(out_tuser), 64'(want.result_null));
          if (out_tdata[1:0] !== want.status)
            report_mismatch("status", 64'(out_tdata[1:0]), 64'(want.status));
          if (out_tdata[65:2] !== want.seconds)
            report_mismatch("seconds", out_tdata[65:2], want.seconds);
          if (out_tdata[86:66] !== want.microseconds)
            report_mismatch("microseconds", 64'(out_tdata[86:66]),
                            64'(want.microseconds));
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      quiet_cycles <= 0;
    else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_scaled_float_to_interval_core failed");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    request_t r;
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed: nulls, every unit and alias, bad units, overflow, carry
    r = unit_request($realtobits(1.5), 0, 0, 0);
    r.value_is_null = 1'b1;
    pending_reqs.push_back(r);
    r.value_is_null = 1'b0;
    r.unit_is_null = 1'b1;
    pending_reqs.push_back(r);
    for (int u = 0; u < 6; u++) begin
      pending_reqs.push_back(unit_request($realtobits(-2.25), u, 0, 1));
      pending_reqs.push_back(unit_request($realtobits(0.3333), u, 1, 1));
    end
    for (int l = 0; l < 8; l += 7) begin
      r = unit_request($realtobits(1.0), 5, 0, 0);
      r.unit_len = 3'(l);
      pending_reqs.push_back(r);
    end
    r = unit_request($realtobits(1.0), 5, 1, 0);
    r.unit_len = 3'd1;
    pending_reqs.push_back(r);
    r = unit_request($realtobits(1.0), 1, 0, 0);
    r.unit_chars[7:0] = "X";
    pending_reqs.push_back(r);
    pending_reqs.push_back(unit_request(64'h7ff8000000000000, 5, 0, 0));
    pending_reqs.push_back(unit_request(64'hfff0000000000000, 2, 1, 0));
    pending_reqs.push_back(unit_request($realtobits(1e300), 0, 0, 0));
    pending_reqs.push_back(unit_request($realtobits(9e18), 5, 0, 0));
    pending_reqs.push_back(unit_request(64'hc3df3e0b4e0b0000, 5, 1, 0));
    pending_reqs.push_back(unit_request($realtobits(0.9999996), 5, 0, 0));
    pending_reqs.push_back(unit_request($realtobits(-0.9999996), 5, 1, 0));
    pending_reqs.push_back(unit_request(64'hffffffffffffffff, 4, 0, 0));
    pending_reqs.push_back(unit_request(64'h0000000000000001, 3, 0, 0));

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 86 : 0;
      recv_stall_pct = (phase == 0) ? 86 : (phase == 1) ? 13 : 0;
      repeat (333) pending_reqs.push_back(random_request());
      while (pending_reqs.size() > 0) @(posedge clk);
    end

    while (in_tvalid || expected_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("tb_scaled_float_to_interval_core passed");
    else
      $display("tb_scaled_float_to_interval_core failed");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/sfti_pkg.sv
hdl/sfti_front.sv
hdl/sfti_queue.sv
hdl/sfti_back.sv
hdl/scaled_float_to_interval_core.sv
bench/tb_scaled_float_to_interval_core.sv
